/* src/lrtm_pkg.sv */
// ----------------------------------------------------------------------------
// Low-rank triangular matrix-vector product: shared definitions
// Command, mode, status and register codes, the control state type and the
// control group that the sequencer passes to the arithmetic unit.
// ----------------------------------------------------------------------------
package lrtm_pkg;

	localparam int VAL_W      = 32;
	localparam int ACC_W      = 48;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [2:0] CMD_LOAD_U  = 3'd0;
	localparam logic [2:0] CMD_LOAD_V  = 3'd1;
	localparam logic [2:0] CMD_LOAD_X  = 3'd2;
	localparam logic [2:0] CMD_COMPUTE = 3'd3;
	localparam logic [2:0] CMD_READ    = 3'd4;

	localparam logic [2:0] MODE_FULL       = 3'd0;
	localparam logic [2:0] MODE_LOWER      = 3'd1;
	localparam logic [2:0] MODE_ANTI_LOWER = 3'd2;
	localparam logic [2:0] MODE_UPPER      = 3'd3;
	localparam logic [2:0] MODE_ANTI_UPPER = 3'd4;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_BAD_MODE = 2'd1;
	localparam logic [1:0] STAT_SAT      = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANK   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd2;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_TERM,
		ST_RD,
		ST_MUL_VX,
		ST_W,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_PW,
		ST_WR,
		ST_RDY,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic w_clr;
		logic flag_clr;
		logic mul_vx;
		logic mul_lo;
		logic mul_hi;
		logic w_upd;
		logic pw_upd;
		logic y_upd;
	} mac_ctl_t;

endpackage

/* src/low_rank_triangular_matvec.sv */
// ----------------------------------------------------------------------------
// Low-rank triangular matrix-vector product
// Holds R factor rows U and V and a vector x in memories and forms
// y = (sum of U_r V_r^T) x, masked to full, lower, anti-lower, upper or
// anti-upper form, in signed Q16.16 with 48-bit saturating accumulation.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake              Payload
//   -------  ---------------------  -----------------------------------------
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//   in       in_valid / in_ready    command, term_index, position, value
//   out      out_valid / out_ready  out_position, out_value, status
//
// Loads are written as they are accepted. A read passes RDY and OUT before
// its item enters the output register. A compute clears the whole result
// memory, then per term passes TERM and per element adds V*x to the weight
// (RD, MUL_VX, W) and w*U to the result (MUL_LO, MUL_HI, PW, WR); full mode
// sums the weight over all elements first and reads each again for the
// update. Every step shares one 32x32 multiplier and the result memory. Reset
// clears the control, the registers, the running weight and the saturation
// flag; the memories keep whatever they held. A stalled output holds its item
// while the block goes on to the next input item; only a second result waits.
//
module low_rank_triangular_matvec #(
	parameter int TERMS_MAX  = 16,
	parameter int MAX_LENGTH = 256,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [lrtm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [lrtm_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [2:0]                             command,
	input  logic [3:0]                             term_index,
	input  logic [7:0]                             position,
	input  logic signed [lrtm_pkg::VAL_W-1:0]      value,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [7:0]                             out_position,
	output logic signed [lrtm_pkg::VAL_W-1:0]      out_value,
	output logic [1:0]                             status
);
	import lrtm_pkg::*;

	localparam int LW = $clog2(MAX_LENGTH);
	localparam int RW = (TERMS_MAX > 1) ? $clog2(TERMS_MAX) : 1;

	logic [2:0] mode_q;
	logic [4:0] rank_q;
	logic [8:0] length_q;

	mac_ctl_t                ctl;
	logic                    sat_flag;
	logic                    u_we;
	logic                    v_we;
	logic                    x_we;
	logic [RW+LW-1:0]        uv_waddr;
	logic [LW-1:0]           x_waddr;
	logic                    rd_en;
	logic [RW+LW-1:0]        u_raddr;
	logic [RW+LW-1:0]        v_raddr;
	logic [LW-1:0]           x_raddr;
	logic                    y_we;
	logic [LW-1:0]           y_waddr;
	logic signed [ACC_W-1:0] y_wdata;
	logic                    y_re;
	logic [LW-1:0]           y_raddr;
	logic signed [VAL_W-1:0] u_rd;
	logic signed [VAL_W-1:0] v_rd;
	logic signed [VAL_W-1:0] x_rd;
	logic signed [ACC_W-1:0] y_rd;
	logic signed [ACC_W-1:0] y_wr;

	// Configuration registers are always writable; the user writes them only
	// while no item is in flight. Unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_FULL;
			rank_q   <= 5'd1;
			length_q <= 9'd256;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MODE:   mode_q   <= cfg_data[2:0];
				CFG_RANK:   rank_q   <= cfg_data[4:0];
				CFG_LENGTH: length_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// Factor rows are addressed by term in the upper bits and element below.
	lrtm_ram #(.DATA_W(VAL_W), .ADDR_W(RW + LW)) u_u_ram (
		.clk(clk), .we(u_we), .waddr(uv_waddr), .wdata(value),
		.re(rd_en), .raddr(u_raddr), .rdata(u_rd)
	);

	lrtm_ram #(.DATA_W(VAL_W), .ADDR_W(RW + LW)) u_v_ram (
		.clk(clk), .we(v_we), .waddr(uv_waddr), .wdata(value),
		.re(rd_en), .raddr(v_raddr), .rdata(v_rd)
	);

	lrtm_ram #(.DATA_W(VAL_W), .ADDR_W(LW)) u_x_ram (
		.clk(clk), .we(x_we), .waddr(x_waddr), .wdata(value),
		.re(rd_en), .raddr(x_raddr), .rdata(x_rd)
	);

	// The result memory is read in the RD state and written back in the WR
	// state; only one element is in flight, so no forwarding is needed.
	lrtm_ram #(.DATA_W(ACC_W), .ADDR_W(LW)) u_y_ram (
		.clk(clk), .we(y_we), .waddr(y_waddr), .wdata(y_wdata),
		.re(y_re), .raddr(y_raddr), .rdata(y_rd)
	);

	lrtm_ctrl #(.TERMS_MAX(TERMS_MAX), .MAX_LENGTH(MAX_LENGTH), .LW(LW), .RW(RW)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .term_index(term_index), .position(position),
		.mode(mode_q), .rank_used(rank_q), .length(length_q),
		.ctl(ctl), .sat_flag(sat_flag),
		.u_we(u_we), .v_we(v_we), .x_we(x_we),
		.uv_waddr(uv_waddr), .x_waddr(x_waddr),
		.rd_en(rd_en), .u_raddr(u_raddr), .v_raddr(v_raddr), .x_raddr(x_raddr),
		.y_we(y_we), .y_waddr(y_waddr), .y_wdata(y_wdata),
		.y_re(y_re), .y_raddr(y_raddr), .y_rd(y_rd), .y_wr(y_wr),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_position(out_position), .out_value(out_value), .status(status)
	);

	lrtm_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.v_rd(v_rd), .x_rd(x_rd), .u_rd(u_rd), .y_rd(y_rd),
		.y_wr(y_wr), .sat_flag(sat_flag)
	);

endmodule

/* src/lrtm_ram.sv */
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lrtm_ram #(
	parameter int DATA_W = 32,
	parameter int ADDR_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [1 << ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/lrtm_mac.sv */
// ----------------------------------------------------------------------------
// Multiply-accumulate unit
// One shared 32x32 magnitude multiplier forms V*x and, in two halves, w*U.
// Keeps the running weight, the saturated term and the saturation flag.
// ----------------------------------------------------------------------------
module lrtm_mac #(
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lrtm_pkg::mac_ctl_t              ctl,
	input  logic signed [lrtm_pkg::VAL_W-1:0] v_rd,
	input  logic signed [lrtm_pkg::VAL_W-1:0] x_rd,
	input  logic signed [lrtm_pkg::VAL_W-1:0] u_rd,
	input  logic signed [lrtm_pkg::ACC_W-1:0] y_rd,
	output logic signed [lrtm_pkg::ACC_W-1:0] y_wr,
	output logic                            sat_flag
);
	import lrtm_pkg::*;

	localparam int SW = 66;

	logic [63:0]             prod_q;
	logic [63:0]             lo_q;
	logic                    neg_q;
	logic signed [ACC_W-1:0] w_q;
	logic signed [ACC_W-1:0] pw_q;
	logic                    flag_q;

	logic [31:0]             mul_a;
	logic [31:0]             mul_b;
	logic [63:0]             product;
	logic [ACC_W-1:0]        w_mag;
	logic [63:0]             s_mag;
	logic signed [SW-1:0]    s_term;
	logic [ACC_W:0]          w_sat;
	logic [63:0]             wide_mag;
	logic signed [ACC_W-1:0] pw_val;
	logic                    pw_clip;
	logic [ACC_W:0]          y_sat;

	function automatic logic [31:0] mag32(logic signed [31:0] a);
		return a[31] ? 32'(-a) : 32'(a);
	endfunction

	// Returns the clip bit above the 48-bit saturated value.
	function automatic logic [ACC_W:0] sat_acc(logic signed [SW-1:0] v);
		logic [ACC_W:0] r;
		if (v > SW'(ACC_MAX)) begin
			r = {1'b1, ACC_MAX};
		end else if (v < SW'(ACC_MIN)) begin
			r = {1'b1, ACC_MIN};
		end else begin
			r = {1'b0, v[ACC_W-1:0]};
		end
		return r;
	endfunction

	assign w_mag = w_q[ACC_W-1] ? ACC_W'(-w_q) : ACC_W'(w_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (ctl.mul_vx) begin
			mul_a = mag32(v_rd);
			mul_b = mag32(x_rd);
		end else if (ctl.mul_lo) begin
			mul_a = w_mag[31:0];
			mul_b = mag32(u_rd);
		end else if (ctl.mul_hi) begin
			mul_a = 32'(w_mag[ACC_W-1:32]);
			mul_b = mag32(u_rd);
		end
	end

	assign product = 64'(mul_a) * 64'(mul_b);

	// V*x scaled back, truncated toward zero, added to the running weight.
	assign s_mag  = prod_q >> FRAC_BITS;
	assign s_term = neg_q ? -$signed({2'b00, s_mag}) : $signed({2'b00, s_mag});
	assign w_sat  = sat_acc(SW'(w_q) + s_term);

	// w*U from its high and low halves; a high half that is too large clips.
	always_comb begin
		if (prod_q >= (64'd1 << (16 + FRAC_BITS))) begin
			wide_mag = 64'd1 << ACC_W;
		end else begin
			wide_mag = (prod_q << (32 - FRAC_BITS)) + (lo_q >> FRAC_BITS);
		end
		pw_clip = 1'b0;
		if (neg_q) begin
			if (wide_mag > (64'd1 << (ACC_W - 1))) begin
				pw_val  = ACC_MIN;
				pw_clip = 1'b1;
			end else begin
				pw_val = ACC_W'(-wide_mag);
			end
		end else begin
			if (wide_mag > 64'(ACC_MAX)) begin
				pw_val  = ACC_MAX;
				pw_clip = 1'b1;
			end else begin
				pw_val = ACC_W'(wide_mag);
			end
		end
	end

	assign y_sat    = sat_acc(SW'(y_rd) + SW'(pw_q));
	assign y_wr     = y_sat[ACC_W-1:0];
	assign sat_flag = flag_q;

	always_ff @(posedge clk) begin
		if (ctl.mul_vx || ctl.mul_lo || ctl.mul_hi) begin
			prod_q <= product;
		end
		if (ctl.mul_vx) begin
			neg_q <= v_rd[VAL_W-1] ^ x_rd[VAL_W-1];
		end else if (ctl.mul_lo) begin
			neg_q <= w_q[ACC_W-1] ^ u_rd[VAL_W-1];
		end
		if (ctl.mul_hi) begin
			lo_q <= prod_q;
		end
		if (ctl.pw_upd) begin
			pw_q <= pw_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= '0;
			flag_q <= 1'b0;
		end else begin
			if (ctl.w_clr) begin
				w_q <= '0;
			end else if (ctl.w_upd) begin
				w_q <= w_sat[ACC_W-1:0];
			end
			if (ctl.flag_clr) begin
				flag_q <= 1'b0;
			end else if ((ctl.w_upd && w_sat[ACC_W]) || (ctl.pw_upd && pw_clip)
					|| (ctl.y_upd && y_sat[ACC_W])) begin
				flag_q <= 1'b1;
			end
		end
	end

endmodule

/* src/lrtm_ctrl.sv */
// ----------------------------------------------------------------------------
// Sequencer
// Takes items, drives the factor, vector and result memories, walks the
// terms and elements of a compute and holds the result item register.
// ----------------------------------------------------------------------------
module lrtm_ctrl #(
	parameter int TERMS_MAX  = 16,
	parameter int MAX_LENGTH = 256,
	parameter int LW = $clog2(MAX_LENGTH),
	parameter int RW = (TERMS_MAX > 1) ? $clog2(TERMS_MAX) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [2:0]                        command,
	input  logic [3:0]                        term_index,
	input  logic [7:0]                        position,
	input  logic [2:0]                        mode,
	input  logic [4:0]                        rank_used,
	input  logic [8:0]                        length,
	output lrtm_pkg::mac_ctl_t                ctl,
	input  logic                              sat_flag,
	output logic                              u_we,
	output logic                              v_we,
	output logic                              x_we,
	output logic [RW+LW-1:0]                  uv_waddr,
	output logic [LW-1:0]                     x_waddr,
	output logic                              rd_en,
	output logic [RW+LW-1:0]                  u_raddr,
	output logic [RW+LW-1:0]                  v_raddr,
	output logic [LW-1:0]                     x_raddr,
	output logic                              y_we,
	output logic [LW-1:0]                     y_waddr,
	output logic signed [lrtm_pkg::ACC_W-1:0] y_wdata,
	output logic                              y_re,
	output logic [LW-1:0]                     y_raddr,
	input  logic signed [lrtm_pkg::ACC_W-1:0] y_rd,
	input  logic signed [lrtm_pkg::ACC_W-1:0] y_wr,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [7:0]                        out_position,
	output logic signed [lrtm_pkg::VAL_W-1:0] out_value,
	output logic [1:0]                        status
);
	import lrtm_pkg::*;

	localparam int JW = $clog2(MAX_LENGTH + 1);
	localparam int TW = $clog2(TERMS_MAX + 1);

	state_t state_q, state_d;

	logic [JW-1:0]           j_q;
	logic [JW-1:0]           clr_q;
	logic [TW-1:0]           t_q;
	logic                    phase_q;
	logic                    rd_ok_q;
	logic [7:0]              pend_pos_q;
	logic signed [VAL_W-1:0] pend_val_q;
	logic [1:0]              pend_stat_q;
	logic                    out_valid_q;
	logic [7:0]              out_pos_q;
	logic signed [VAL_W-1:0] out_val_q;
	logic [1:0]              out_stat_q;

	logic                    accept;
	logic                    pos_ok;
	logic                    term_ok;
	logic [JW-1:0]           n_len;
	logic [TW-1:0]           r_used;
	logic                    full;
	logic                    asc_acc;
	logic                    asc_tgt;
	logic [JW-1:0]           j_rev;
	logic [LW-1:0]           a_idx;
	logic [LW-1:0]           d_idx;
	logic                    j_last;
	logic                    out_load;
	logic signed [VAL_W-1:0] rd_val;
	logic                    rd_clip;

	assign accept  = in_valid && in_ready;
	assign pos_ok  = 32'(position) < MAX_LENGTH;
	assign term_ok = 32'(term_index) < TERMS_MAX;

	always_comb begin
		if (length == 9'd0) begin
			n_len = JW'(1);
		end else if (32'(length) > MAX_LENGTH) begin
			n_len = JW'(MAX_LENGTH);
		end else begin
			n_len = JW'(length);
		end
		if (32'(rank_used) > TERMS_MAX) begin
			r_used = TW'(TERMS_MAX);
		end else begin
			r_used = TW'(rank_used);
		end
	end

	assign full    = (mode == MODE_FULL);
	assign asc_acc = full || (mode == MODE_LOWER) || (mode == MODE_ANTI_UPPER);
	assign asc_tgt = full || (mode == MODE_LOWER) || (mode == MODE_ANTI_LOWER);
	assign j_rev   = n_len - JW'(1) - j_q;
	assign a_idx   = asc_acc ? j_q[LW-1:0] : j_rev[LW-1:0];
	assign d_idx   = asc_tgt ? j_q[LW-1:0] : j_rev[LW-1:0];
	assign j_last  = (j_q == n_len - JW'(1));

	// Memory ports.
	assign u_we     = accept && (command == CMD_LOAD_U) && pos_ok && term_ok;
	assign v_we     = accept && (command == CMD_LOAD_V) && pos_ok && term_ok;
	assign x_we     = accept && (command == CMD_LOAD_X) && pos_ok;
	assign uv_waddr = {RW'(term_index), LW'(position)};
	assign x_waddr  = LW'(position);
	assign rd_en    = (state_q == ST_RD);
	assign u_raddr  = {t_q[RW-1:0], d_idx};
	assign v_raddr  = {t_q[RW-1:0], a_idx};
	assign x_raddr  = a_idx;
	assign y_we     = (state_q == ST_CLEAR) || (state_q == ST_WR);
	assign y_waddr  = (state_q == ST_CLEAR) ? clr_q[LW-1:0] : d_idx;
	assign y_wdata  = (state_q == ST_CLEAR) ? '0 : y_wr;
	assign y_re     = (state_q == ST_RD) || (accept && (command == CMD_READ));
	assign y_raddr  = (state_q == ST_RD) ? d_idx : LW'(position);

	// Read-back value clipped to 32 bits.
	always_comb begin
		rd_clip = 1'b0;
		if (y_rd > 48'sd2147483647) begin
			rd_val  = 32'sh7FFFFFFF;
			rd_clip = 1'b1;
		end else if (y_rd < -48'sd2147483648) begin
			rd_val  = 32'sh80000000;
			rd_clip = 1'b1;
		end else begin
			rd_val = y_rd[VAL_W-1:0];
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		out_load     = 1'b0;
		ctl          = '0;
		ctl.w_clr    = (state_q == ST_TERM);
		ctl.flag_clr = (state_q == ST_CLEAR);
		ctl.mul_vx   = (state_q == ST_MUL_VX);
		ctl.mul_lo   = (state_q == ST_MUL_LO);
		ctl.mul_hi   = (state_q == ST_MUL_HI);
		ctl.w_upd    = (state_q == ST_W);
		ctl.pw_upd   = (state_q == ST_PW);
		ctl.y_upd    = (state_q == ST_WR);
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (command)
						CMD_COMPUTE: state_d = (mode > MODE_ANTI_UPPER) ? ST_OUT : ST_CLEAR;
						CMD_READ:    state_d = ST_RDY;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_CLEAR: begin
				if (clr_q == JW'(MAX_LENGTH - 1)) begin
					state_d = ST_TERM;
				end
			end
			ST_TERM:   state_d = (t_q == r_used) ? ST_OUT : ST_RD;
			ST_RD:     state_d = (full && phase_q) ? ST_MUL_LO : ST_MUL_VX;
			ST_MUL_VX: state_d = ST_W;
			ST_W:      state_d = full ? ST_RD : ST_MUL_LO;
			ST_MUL_LO: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_PW;
			ST_PW:     state_d = ST_WR;
			ST_WR:     state_d = j_last ? ST_TERM : ST_RD;
			ST_RDY:    state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			j_q         <= '0;
			clr_q       <= '0;
			t_q         <= '0;
			phase_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					clr_q <= '0;
					t_q   <= '0;
				end
				ST_CLEAR: clr_q <= clr_q + JW'(1);
				ST_TERM: begin
					j_q     <= '0;
					phase_q <= 1'b0;
				end
				ST_W: begin
					if (full) begin
						if (j_last) begin
							j_q     <= '0;
							phase_q <= 1'b1;
						end else begin
							j_q <= j_q + JW'(1);
						end
					end
				end
				ST_WR: begin
					if (j_last) begin
						t_q <= t_q + TW'(1);
					end else begin
						j_q <= j_q + JW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_pos_q  <= (command == CMD_READ) ? position : 8'd0;
			pend_val_q  <= '0;
			pend_stat_q <= STAT_BAD_MODE;
			rd_ok_q     <= pos_ok;
		end
		if (state_q == ST_TERM) begin
			pend_stat_q <= sat_flag ? STAT_SAT : STAT_OK;
		end
		if (state_q == ST_RDY) begin
			pend_val_q  <= rd_ok_q ? rd_val : '0;
			pend_stat_q <= (rd_ok_q && (rd_clip || sat_flag)) ? STAT_SAT : STAT_OK;
		end
		if (out_load) begin
			out_pos_q  <= pend_pos_q;
			out_val_q  <= pend_val_q;
			out_stat_q <= pend_stat_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_position = out_pos_q;
	assign out_value    = out_val_q;
	assign status       = out_stat_q;

endmodule

/* src/lrtm_check.sv */
// ----------------------------------------------------------------------------
// Port checker for the low-rank triangular matrix-vector product
// Watches the top-level ports over time; attached by a bind statement.
// ----------------------------------------------------------------------------
module lrtm_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [2:0]                    command,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [7:0]                    out_position,
	input logic signed [lrtm_pkg::VAL_W-1:0] out_value,
	input logic [1:0]                    status
);
	import lrtm_pkg::*;

	// A compute or a read occupies the block for at least the next cycle.
	a_busy_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (command == CMD_COMPUTE || command == CMD_READ)
		|=> !in_ready)
		else $error("input taken straight after a compute or read item");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("result item carries an undefined status");

	a_bad_mode_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_BAD_MODE |-> out_position == 8'd0 && out_value == '0)
		else $error("bad-mode result item carries data");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(status))
		else $error("stalled result item changed or vanished");

endmodule

bind low_rank_triangular_matvec lrtm_check u_lrtm_check (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_valid), .in_ready(in_ready), .command(command),
	.out_valid(out_valid), .out_ready(out_ready),
	.out_position(out_position), .out_value(out_value), .status(status)
);

/* bench/lrtm_checker.sv */
// ----------------------------------------------------------------------------
// Low-rank triangular matrix-vector product: result checker
// Watches the configuration, input and output channels, keeps its own copy of
// the factor, vector and result stores, predicts every result item and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module lrtm_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [lrtm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lrtm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [2:0]                        command,
	input  logic [3:0]                        term_index,
	input  logic [7:0]                        position,
	input  logic signed [lrtm_pkg::VAL_W-1:0] value,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [7:0]                        out_position,
	input  logic signed [lrtm_pkg::VAL_W-1:0] out_value,
	input  logic [1:0]                        status,
	output int                                fail_count,
	output int                                pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import lrtm_pkg::*;

	localparam int ROWS = 16;
	localparam int COLS = 256;

	typedef logic signed [95:0] wide_t;

	typedef struct {
		logic [7:0]              pos;
		logic signed [VAL_W-1:0] val;
		logic [1:0]              stat;
	} readback_t;

	logic signed [VAL_W-1:0] u_mem [ROWS*COLS];
	logic signed [VAL_W-1:0] v_mem [ROWS*COLS];
	logic signed [VAL_W-1:0] x_mem [COLS];
	logic signed [ACC_W-1:0] y_mem [COLS];
	logic signed [ACC_W-1:0] weight;
	bit                      clipped;
	logic [2:0]              mode_reg;
	logic [4:0]              rank_reg;
	logic [8:0]              length_reg;
	readback_t               awaited [$];
	int                      errors;

	assign fail_count = errors;
	assign pending    = awaited.size();

	initial begin
		errors = 0;
		weight = '0;
		clipped = 0;
		mode_reg = MODE_FULL;
		rank_reg = 5'd1;
		length_reg = 9'd256;
		for (int i = 0; i < ROWS*COLS; i++) begin
			u_mem[i] = '0;
			v_mem[i] = '0;
		end
		for (int i = 0; i < COLS; i++) begin
			x_mem[i] = '0;
			y_mem[i] = '0;
		end
	end

	task automatic report(string what, longint want, longint got);
		$display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
		errors++;
	endtask

	// Clamp to the 48-bit accumulator range and note the clip.
	function automatic logic signed [ACC_W-1:0] clamp48(wide_t v);
		if (v > wide_t'(ACC_MAX)) begin
			clipped = 1;
			return ACC_MAX;
		end
		if (v < wide_t'(ACC_MIN)) begin
			clipped = 1;
			return ACC_MIN;
		end
		return v[ACC_W-1:0];
	endfunction

	// V*x, rescaled by truncation toward zero.
	function automatic wide_t scaled_vx(logic signed [VAL_W-1:0] a,
			logic signed [VAL_W-1:0] b);
		wide_t p;
		wide_t m;
		p = wide_t'(a) * wide_t'(b);
		m = (p < 0) ? -p : p;
		m = m >> 16;
		return (p < 0) ? -m : m;
	endfunction

	// w*U, rescaled toward zero and clamped; a negative magnitude of exactly
	// 2^47 still fits.
	function automatic wide_t scaled_wu(logic signed [ACC_W-1:0] w,
			logic signed [VAL_W-1:0] u);
		wide_t p;
		wide_t m;
		bit    neg;
		neg = (w < 0) != (u < 0);
		p = wide_t'(w) * wide_t'(u);
		m = (p < 0) ? -p : p;
		m = m >> 16;
		if (neg) begin
			if (m > (wide_t'(1) <<< 47)) begin
				clipped = 1;
				return wide_t'(ACC_MIN);
			end
			return -m;
		end
		if (m > wide_t'(ACC_MAX)) begin
			clipped = 1;
			return wide_t'(ACC_MAX);
		end
		return m;
	endfunction

	task automatic form_product();
		int n;
		int r;
		int a;
		int d;
		bit asc_acc;
		bit asc_tgt;
		logic signed [ACC_W-1:0] w;
		n = (length_reg == 0) ? 1 : ((length_reg > COLS) ? COLS : int'(length_reg));
		r = (rank_reg > ROWS) ? ROWS : int'(rank_reg);
		asc_acc = (mode_reg == MODE_FULL || mode_reg == MODE_LOWER ||
			mode_reg == MODE_ANTI_UPPER);
		asc_tgt = (mode_reg == MODE_LOWER || mode_reg == MODE_ANTI_LOWER);
		for (int i = 0; i < COLS; i++)
			y_mem[i] = '0;
		clipped = 0;
		for (int t = 0; t < r; t++) begin
			w = '0;
			if (mode_reg == MODE_FULL) begin
				for (int j = 0; j < n; j++)
					w = clamp48(wide_t'(w) + scaled_vx(v_mem[t*COLS+j], x_mem[j]));
				for (int j = 0; j < n; j++)
					y_mem[j] = clamp48(wide_t'(y_mem[j]) + scaled_wu(w, u_mem[t*COLS+j]));
			end else begin
				for (int j = 0; j < n; j++) begin
					a = asc_acc ? j : n - 1 - j;
					d = asc_tgt ? j : n - 1 - j;
					w = clamp48(wide_t'(w) + scaled_vx(v_mem[t*COLS+a], x_mem[a]));
					y_mem[d] = clamp48(wide_t'(y_mem[d]) + scaled_wu(w, u_mem[t*COLS+d]));
				end
			end
			weight = w;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MODE:   mode_reg   = cfg_data[2:0];
				CFG_RANK:   rank_reg   = cfg_data[4:0];
				CFG_LENGTH: length_reg = cfg_data[8:0];
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		readback_t e;
		longint    lv;
		if (arst_n && in_valid && in_ready) begin
			case (command)
				CMD_LOAD_U: u_mem[term_index*COLS + position] = value;
				CMD_LOAD_V: v_mem[term_index*COLS + position] = value;
				CMD_LOAD_X: x_mem[position] = value;
				CMD_COMPUTE: begin
					e.pos = '0;
					e.val = '0;
					if (mode_reg > MODE_ANTI_UPPER) begin
						e.stat = STAT_BAD_MODE;
					end else begin
						form_product();
						e.stat = clipped ? STAT_SAT : STAT_OK;
					end
					awaited.push_back(e);
				end
				CMD_READ: begin
					lv = y_mem[position];
					e.pos = position;
					e.stat = clipped ? STAT_SAT : STAT_OK;
					if (lv > 64'sd2147483647) begin
						lv = 64'sd2147483647;
						e.stat = STAT_SAT;
					end else if (lv < -64'sd2147483648) begin
						lv = -64'sd2147483648;
						e.stat = STAT_SAT;
					end
					e.val = lv[31:0];
					awaited.push_back(e);
				end
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		readback_t e;
		if (arst_n && out_valid && out_ready) begin
			if (awaited.size() == 0) begin
				report("result item with nothing awaited", 0, out_position);
			end else begin
				e = awaited.pop_front();
				if (out_position !== e.pos)
					report("out_position", e.pos, out_position);
				if (out_value !== e.val)
					report("out_value", e.val, out_value);
				if (status !== e.stat)
					report("status", e.stat, status);
			end
		end
	end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// Low-rank triangular matrix-vector product: testbench
// Runs the block through phases of configuration, factor and vector loads,
// computes and read-backs, with random idling on both sides, and gives the
// verdict from the failure count of the checker beside the block.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import lrtm_pkg::*;

	localparam int ROWS = 16;
	localparam int COLS = 256;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [2:0]              command = CMD_LOAD_X;
	logic [3:0]              term_index = '0;
	logic [7:0]              position = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [7:0]              out_position;
	logic signed [VAL_W-1:0] out_value;
	logic [1:0]              status;
	int                      fail_count;
	int                      pending;

	// Which store entries hold a written value; the block's memories are not
	// cleared by reset, so no compute may touch an entry that is still unset.
	bit u_set [ROWS*COLS];
	bit v_set [ROWS*COLS];
	bit x_set [COLS];
	bit result_valid;  // a compute in a legal mode has filled the result store
	bit calm;          // while set, neither side idles
	int items_sent;

	low_rank_triangular_matvec u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .term_index(term_index),
		.position(position), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_position(out_position), .out_value(out_value), .status(status)
	);

	lrtm_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .term_index(term_index),
		.position(position), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_position(out_position), .out_value(out_value), .status(status),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver stalls with a probability of about 18 percent, except while calm.
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 18);
	end

	// A value mix: mostly modest Q16.16 numbers, some raw 32-bit patterns and
	// the extremes, so that both ordinary sums and saturation are reached.
	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(7))
			0, 1: return $urandom;
			6: begin
				case ($urandom_range(4))
					0: return 32'sh7FFF_FFFF;
					1: return 32'sh8000_0000;
					2: return 32'sd0;
					3: return -32'sd1;
					default: return 32'sd1;
				endcase
			end
			7: return 32'(($urandom_range(16) - 8) * 65536);
			default: return 32'(int'($urandom_range(524288)) - 262144);
		endcase
	endfunction

	// Offers one item on the input channel and waits until it is taken.
	task automatic send(logic [2:0] cmd, logic [3:0] term, logic [7:0] pos,
			logic signed [VAL_W-1:0] val);
		while (!calm && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		command    <= cmd;
		term_index <= term;
		position   <= pos;
		value      <= val;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (cmd == CMD_LOAD_U)
			u_set[term*COLS + pos] = 1;
		else if (cmd == CMD_LOAD_V)
			v_set[term*COLS + pos] = 1;
		else if (cmd == CMD_LOAD_X)
			x_set[pos] = 1;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		while (!calm && $urandom_range(99) < 18) begin
			cfg_valid <= 1'b0;
			@(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Drains every awaited result, then waits on so that a trailing load has
	// settled before the registers change.
	task automatic drain();
		in_valid  <= 1'b0;
		cfg_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	// A stray item: a load anywhere, or a command the block ignores.
	task automatic send_noise();
		logic [2:0] cmd;
		cmd = $urandom_range(1) ? 3'($urandom_range(2)) : 3'($urandom_range(7, 5));
		send(cmd, 4'($urandom), 8'($urandom), pick_value());
	endtask

	// Well-formed load sequence: every entry that the coming compute will use
	// is written, and entries already written are rewritten now and then.
	task automatic fill(int r, int n);
		for (int j = 0; j < n; j++) begin
			if (!x_set[j] || $urandom_range(99) < 30)
				send(CMD_LOAD_X, 4'($urandom), 8'(j), pick_value());
			for (int t = 0; t < r; t++) begin
				if (!u_set[t*COLS + j] || $urandom_range(99) < 30)
					send(CMD_LOAD_U, 4'(t), 8'(j), pick_value());
				if (!v_set[t*COLS + j] || $urandom_range(99) < 30)
					send(CMD_LOAD_V, 4'(t), 8'(j), pick_value());
				if ($urandom_range(99) < 8)
					send_noise();
			end
		end
	endtask

	// One phase: set the registers while idle, load, compute, read back.
	task automatic phase(logic [2:0] m, logic [4:0] rk, logic [8:0] len, int reads);
		int n;
		int r;
		n = (len == 0) ? 1 : ((len > COLS) ? COLS : int'(len));
		r = (rk > ROWS) ? ROWS : int'(rk);
		drain();
		write_reg(CFG_MODE, 9'(m));
		write_reg(CFG_RANK, 9'(rk));
		write_reg(CFG_LENGTH, len);
		cfg_valid <= 1'b0;
		if (m <= MODE_ANTI_UPPER)
			fill(r, n);
		send(CMD_COMPUTE, 4'($urandom), 8'($urandom), $urandom);
		if (m <= MODE_ANTI_UPPER)
			result_valid = 1;
		if (result_valid) begin
			for (int i = 0; i < reads; i++) begin
				// Mostly positions inside the vector, some beyond its length.
				if ($urandom_range(99) < 60)
					send(CMD_READ, 4'($urandom), 8'($urandom_range(n - 1)), $urandom);
				else
					send(CMD_READ, 4'($urandom), 8'($urandom), $urandom);
			end
		end
		if ($urandom_range(99) < 25)
			send_noise();
	endtask

	initial begin
		int k;
		items_sent = 0;
		result_valid = 0;
		calm = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: the value extremes at the corners of the stores,
		// the ignored commands, then every mode and an invalid one.
		send(CMD_LOAD_U, 4'd15, 8'd255, 32'sh7FFF_FFFF);
		send(CMD_LOAD_V, 4'd15, 8'd255, 32'sh8000_0000);
		send(CMD_LOAD_X, 4'd0, 8'd255, 32'sh7FFF_FFFF);
		send(3'd5, 4'd15, 8'd255, -32'sd1);
		send(3'd6, 4'd0, 8'd0, 32'sd0);
		send(3'd7, 4'd8, 8'd128, 32'sh8000_0000);
		send(CMD_LOAD_U, 4'd0, 8'd0, 32'sh7FFF_FFFF);
		send(CMD_LOAD_V, 4'd0, 8'd0, 32'sh7FFF_FFFF);
		send(CMD_LOAD_X, 4'd0, 8'd0, 32'sh8000_0000);
		phase(MODE_FULL, 5'd2, 9'd4, 3);
		phase(MODE_LOWER, 5'd2, 9'd4, 2);
		phase(MODE_ANTI_LOWER, 5'd2, 9'd4, 2);
		phase(MODE_UPPER, 5'd2, 9'd4, 2);
		phase(MODE_ANTI_UPPER, 5'd2, 9'd4, 2);
		phase(3'd7, 5'd2, 9'd4, 1);

		// Random part, with the register extremes placed among small phases.
		k = 0;
		while (k < 10 || items_sent < 180) begin
			case (k)
				1: phase(MODE_FULL, 5'd1, 9'd0, 3);
				2: phase(MODE_UPPER, 5'd31, 9'd3, 3);
				3: phase(MODE_ANTI_LOWER, 5'd16, 9'd2, 3);
				4: phase(MODE_ANTI_UPPER, 5'd0, 9'd5, 3);
				5: phase(3'd5, 5'd3, 9'd4, 2);
				6: phase(3'd6, 5'd1, 9'd1, 2);
				default: begin
					if ($urandom_range(99) < 10)
						phase(3'($urandom_range(7, 5)), 5'($urandom_range(4)),
							9'($urandom_range(1, 10)), 2);
					else
						phase(3'($urandom_range(4)), 5'($urandom_range(4)),
							9'($urandom_range(1, 10)), $urandom_range(1, 6));
				end
			endcase
			k++;
		end

		// A full-length phase with a length beyond the limit, run as one long
		// stretch in which neither side idles.
		calm = 1;
		phase(MODE_UPPER, 5'd1, 9'd511, 6);
		drain();
		calm = 0;
		drain();
		repeat (20) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("low_rank_triangular_matvec: match");
		else
			$display("low_rank_triangular_matvec: mismatch");
		$finish;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#20ms;
		$display("low_rank_triangular_matvec: mismatch");
		$finish;
	end

endmodule

/* filelist.f */
src/lrtm_pkg.sv
src/lrtm_ram.sv
src/lrtm_mac.sv
src/lrtm_ctrl.sv
src/low_rank_triangular_matvec.sv
src/lrtm_check.sv
bench/lrtm_checker.sv
bench/testbench.sv
